/* rtl/core/ttp_pkg.sv */
// Shared types and constants for the trace termination policy table.
// Holds the record layout of the table memory and the command/action codes.
package ttp_pkg;

  localparam int unsigned DefaultEntries   = 64;
  localparam logic [23:0] DefaultSizeLimit = 24'(4 * 1024);
  localparam logic [1:0]  RetLookahead     = 2'd2;
  localparam logic [23:0] SizeMax          = 24'hFF_FFFF;
  localparam logic [15:0] CountMax         = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_SEEN    = 2'd0,
    CMD_DELETED = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_DEFAULT  = 2'd0,
    ACT_END      = 2'd1,
    ACT_CONTINUE = 2'd2
  } action_e;

  typedef struct packed {
    logic        valid;
    logic [63:0] tag;
    logic        call_head;
    logic        has_return;
    logic [1:0]  end_countdown;
    logic [23:0] trace_size;
    logic [15:0] ref_count;
  } rec_t;

endpackage

/* rtl/core/trace_termination_policy_table.sv */
// Trace termination policy table: record memory searched by tag, with a scan engine.
// Depends on ttp_pkg.
//
//  channel | dir | handshake                       | payload
//  s_axis  | in  | s_axis_tvalid / s_axis_tready   | tuser cmd, tdata item fields
//  m_axis  | out | m_axis_tvalid / m_axis_tready   | tdata action, mark_head, table_full
//  cfg     | in  | cfg_valid_i / cfg_ready_o       | cfg_data_i size_limit
//
// An item is handled in steps: SCAN reads every record of the table memory
// (one per cycle), DRAIN takes the last read, and EXEC does the update.
// After reset every record of the memory is swept to clear the valid flags;
// no item is accepted during the sweep. The result sits in an output register,
// so the next item is taken while a result waits; the update stalls only when
// that register is still full.
module trace_termination_policy_table
  import ttp_pkg::*;
#(
  parameter int unsigned ENTRIES = DefaultEntries
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] tag, [127:64] succ_tag, [143:128] next_size, [144] has_call,
  // [152:145] returns_before_call, [153] translating, [159:154] zero
  input  logic [159:0] s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] action, [2] mark_head, [3] table_full, [7:4] zero
  output logic [7:0]   m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [23:0]  cfg_data_i
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_DRAIN, ST_EXEC
  } state_e;

  state_e state_q;
  logic [IW-1:0] cnt_q;
  logic          rd_pend_q;
  logic [23:0]   limit_q;

  // latched item
  logic [1:0]  cmd_q;
  logic [63:0] tag_q, ntag_q;
  logic [15:0] nsize_q;
  logic        call_q, trans_q;
  logic [7:0]  rets_q;

  // scan results
  logic          hit_e_q, hit_n_q, free_q;
  logic [IW-1:0] e_idx_q, free_idx_q;
  rec_t          e_rec_q;
  logic          n_call_q, n_ret_q;

  logic        m_valid_q;
  logic [7:0]  m_data_q;

  // table memory
  rec_t mem_q [ENTRIES];
  rec_t rdata_q;
  logic          we;
  logic [IW-1:0] waddr;
  rec_t          wdata;

  logic s_acc;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready;

  // update decision
  rec_t        upd;
  logic        upd_we;
  logic [IW-1:0] upd_idx;
  action_e     act;
  logic        mark, full;
  logic [8:0]  add;
  logic [16:0] cnt_sum;
  logic [24:0] sz_sum;
  logic [1:0]  cd_dec;

  always_comb begin
    upd     = e_rec_q;
    upd_we  = 1'b0;
    upd_idx = e_idx_q;
    act     = ACT_DEFAULT;
    mark    = 1'b0;
    full    = 1'b0;
    add     = {1'b0, rets_q} + {8'd0, call_q};
    cnt_sum = 17'd0;
    sz_sum  = {1'b0, e_rec_q.trace_size} + {9'd0, nsize_q};
    cd_dec  = e_rec_q.end_countdown - 2'd1;
    case (cmd_e'(cmd_q))
      CMD_SEEN: begin
        if (!trans_q) begin
          mark = call_q;
          if (add != 9'd0) begin
            if (!hit_e_q) begin
              upd         = '0;
              upd.valid   = 1'b1;
              upd.tag     = tag_q;
              upd_idx     = free_idx_q;
            end
            if (hit_e_q || free_q) begin
              cnt_sum = {1'b0, upd.ref_count} + {8'd0, add};
              upd.ref_count = cnt_sum[16] ? CountMax : cnt_sum[15:0];
              if (rets_q != 8'd0) upd.has_return = 1'b1;
              if (call_q) upd.call_head = 1'b1;
              upd_we = 1'b1;
            end else begin
              full = 1'b1;
            end
          end
        end
      end
      CMD_DELETED: begin
        if (hit_e_q) begin
          upd_we = 1'b1;
          if (e_rec_q.ref_count <= 16'd1) begin
            upd.ref_count = 16'd0;
            upd.valid     = 1'b0;
          end else begin
            upd.ref_count = e_rec_q.ref_count - 16'd1;
          end
        end
      end
      CMD_QUERY: begin
        if (!hit_e_q || !e_rec_q.call_head) begin
          act = (hit_n_q && n_call_q) ? ACT_END : ACT_DEFAULT;
        end else if (e_rec_q.end_countdown != 2'd0) begin
          upd_we = 1'b1;
          upd.end_countdown = cd_dec;
          act = (cd_dec == 2'd0) ? ACT_END : ACT_CONTINUE;
        end else begin
          upd_we = 1'b1;
          upd.trace_size = sz_sum[24] ? SizeMax : sz_sum[23:0];
          if (upd.trace_size > limit_q) begin
            act = ACT_END;
          end else begin
            act = ACT_CONTINUE;
            if (hit_n_q && n_ret_q && !n_call_q) upd.end_countdown = RetLookahead;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = cnt_q;
    wdata = '0;
    if (state_q == ST_CLEAR) begin
      we = 1'b1;
    end else if (state_q == ST_EXEC && out_free && upd_we) begin
      we    = 1'b1;
      waddr = upd_idx;
      wdata = upd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[cnt_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= DefaultSizeLimit;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // payload latches, no reset
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      cmd_q   <= s_axis_tuser;
      tag_q   <= s_axis_tdata[63:0];
      ntag_q  <= s_axis_tdata[127:64];
      nsize_q <= s_axis_tdata[143:128];
      call_q  <= s_axis_tdata[144];
      rets_q  <= s_axis_tdata[152:145];
      trans_q <= s_axis_tdata[153];
    end
    if (rd_pend_q) begin
      if (rdata_q.valid && rdata_q.tag == tag_q && !hit_e_q) begin
        e_idx_q <= cnt_q - IW'(1) + ((state_q == ST_DRAIN) ? IW'(1) : IW'(0));
        e_rec_q <= rdata_q;
      end
      if (rdata_q.valid && rdata_q.tag == ntag_q && !hit_n_q) begin
        n_call_q <= rdata_q.call_head;
        n_ret_q  <= rdata_q.has_return;
      end
      if (!rdata_q.valid && !free_q) begin
        free_idx_q <= cnt_q - IW'(1) + ((state_q == ST_DRAIN) ? IW'(1) : IW'(0));
      end
    end
    if (state_q == ST_EXEC && out_free) begin
      m_data_q <= {4'd0, full, mark, act};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
      hit_e_q   <= 1'b0;
      hit_n_q   <= 1'b0;
      free_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= (state_q == ST_EXEC && out_free) ? 1'b1 : (m_valid_q && !m_axis_tready);
      if (rd_pend_q) begin
        if (rdata_q.valid && rdata_q.tag == tag_q) hit_e_q <= 1'b1;
        if (rdata_q.valid && rdata_q.tag == ntag_q) hit_n_q <= 1'b1;
        if (!rdata_q.valid) free_q <= 1'b1;
      end
      rd_pend_q <= (state_q == ST_SCAN);
      case (state_q)
        ST_CLEAR: begin
          if (cnt_q == LastIdx) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + IW'(1);
          end
        end
        ST_IDLE: begin
          if (s_acc) begin
            cnt_q   <= '0;
            hit_e_q <= 1'b0;
            hit_n_q <= 1'b0;
            free_q  <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // hold the counter on the last address so DRAIN can name it
          if (cnt_q == LastIdx) begin
            state_q <= ST_DRAIN;
          end else begin
            cnt_q <= cnt_q + IW'(1);
          end
        end
        ST_DRAIN: begin
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/ttp_checker.sv */
// Port-level checks for the trace termination policy table, bound to the top.
// Depends on ttp_pkg for the action codes.
module ttp_checker
  import ttp_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_act_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("illegal action code");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken while an item is in work");

  a_full_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[1:0] == ACT_DEFAULT)
    else $error("table_full with a query action");

  a_mark_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == ACT_DEFAULT)
    else $error("mark_head with a query action");

endmodule

bind trace_termination_policy_table ttp_checker u_ttp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* tb/sv/testbench.sv */
// Self-checking bench for trace_termination_policy_table: streams seen, deleted, query
// and unused beats, predicts each result in its own copy of the record table and compares.
// Depends on ttp_pkg and the block's RTL.
module testbench;
  import ttp_pkg::*;

  localparam int NREC = DefaultEntries;
  localparam int NPOOL = 72;

  typedef struct {
    cmd_e        cmd;
    logic [63:0] tag;
    logic [63:0] succ_tag;
    logic [15:0] next_size;
    logic        has_call;
    logic [7:0]  rets;
    logic        translating;
  } policy_item_t;

  typedef struct {
    action_e action;
    logic    mark_head;
    logic    table_full;
  } policy_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = CMD_NONE;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [23:0]  cfg_data_i = '0;

  trace_termination_policy_table dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted table state
  logic [23:0] pred_limit = DefaultSizeLimit;
  logic        rec_valid [NREC];
  logic [63:0] rec_tag   [NREC];
  logic        rec_call  [NREC];
  logic        rec_ret   [NREC];
  logic [1:0]  rec_cdown [NREC];
  logic [23:0] rec_size  [NREC];
  logic [15:0] rec_count [NREC];

  policy_item_t item_q[$];
  policy_res_t  result_q[$];
  policy_item_t cur_item;
  logic [63:0]  tag_pool [NPOOL];
  int send_idle = 24, recv_idle = 47;
  int errors = 0, n_sent = 0, n_recv = 0, n_full = 0, n_end = 0;
  int hold_cnt = 0;
  bit held = 0;

  function automatic int find_rec(logic [63:0] t);
    for (int i = 0; i < NREC; i++)
      if (rec_valid[i] && rec_tag[i] == t) return i;
    return -1;
  endfunction

  function automatic policy_res_t policy_step(policy_item_t it);
    policy_res_t r;
    int e, n;
    logic [16:0] cnt;
    logic [24:0] sz;
    r = '{ACT_DEFAULT, 1'b0, 1'b0};
    case (it.cmd)
      CMD_SEEN: if (!it.translating) begin
        r.mark_head = it.has_call;
        if (it.rets != 0 || it.has_call) begin
          e = find_rec(it.tag);
          if (e < 0) begin
            for (int i = NREC - 1; i >= 0; i--) if (!rec_valid[i]) e = i;
            if (e >= 0) begin
              rec_valid[e] = 1'b1; rec_tag[e] = it.tag; rec_call[e] = 1'b0;
              rec_ret[e] = 1'b0; rec_cdown[e] = '0; rec_size[e] = '0; rec_count[e] = '0;
            end
          end
          if (e < 0) r.table_full = 1'b1;
          else begin
            cnt = rec_count[e] + it.rets + it.has_call;
            rec_count[e] = cnt[16] ? CountMax : cnt[15:0];
            if (it.rets != 0) rec_ret[e] = 1'b1;
            if (it.has_call) rec_call[e] = 1'b1;
          end
        end
      end
      CMD_DELETED: begin
        e = find_rec(it.tag);
        if (e >= 0) begin
          if (rec_count[e] <= 1) begin
            rec_count[e] = '0; rec_valid[e] = 1'b0;
          end else rec_count[e] = rec_count[e] - 16'd1;
        end
      end
      CMD_QUERY: begin
        e = find_rec(it.tag);
        n = find_rec(it.succ_tag);
        if (e < 0 || !rec_call[e]) begin
          if (n >= 0 && rec_call[n]) r.action = ACT_END;
        end else if (rec_cdown[e] != 0) begin
          rec_cdown[e] = rec_cdown[e] - 2'd1;
          r.action = (rec_cdown[e] == 0) ? ACT_END : ACT_CONTINUE;
        end else begin
          sz = rec_size[e] + it.next_size;
          rec_size[e] = sz[24] ? SizeMax : sz[23:0];
          if (rec_size[e] > pred_limit) r.action = ACT_END;
          else begin
            if (n >= 0 && rec_ret[n] && !rec_call[n]) rec_cdown[e] = RetLookahead;
            r.action = ACT_CONTINUE;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: predict on acceptance, then offer the next pending beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        result_q.push_back(policy_step(cur_item));
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (item_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur_item = item_q.pop_front();
          s_axis_tdata <= {6'd0, cur_item.translating, cur_item.rets, cur_item.has_call,
                           cur_item.next_size, cur_item.succ_tag, cur_item.tag};
          s_axis_tuser <= cur_item.cmd;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long hold-off once, so the block backs up and stalls its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
      held <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!held && n_recv >= 600) begin
      held <= 1'b1;
      hold_cnt <= 400;
    end
  end

  // Monitor: check each result beat against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    policy_res_t exp_r;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_recv++;
        if (result_q.size() == 0) begin
          $error("result beat with no prediction waiting: %h", m_axis_tdata);
          errors++;
        end else begin
          exp_r = result_q.pop_front();
          if (exp_r.table_full) n_full++;
          if (exp_r.action == ACT_END) n_end++;
          if (m_axis_tdata[1:0] !== exp_r.action) begin
            $error("action: expected %0d, got %0d", exp_r.action, m_axis_tdata[1:0]);
            errors++;
          end
          if (m_axis_tdata[2] !== exp_r.mark_head) begin
            $error("mark_head: expected %0d, got %0d", exp_r.mark_head, m_axis_tdata[2]);
            errors++;
          end
          if (m_axis_tdata[3] !== exp_r.table_full) begin
            $error("table_full: expected %0d, got %0d", exp_r.table_full, m_axis_tdata[3]);
            errors++;
          end
          if (m_axis_tdata[7:4] !== 4'd0) begin
            $error("pad: expected 0, got %0d", m_axis_tdata[7:4]);
            errors++;
          end
        end
      end
      m_axis_tready <= (hold_cnt > 0) ? 1'b0 : ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic add_item(cmd_e c, logic [63:0] t, logic [63:0] nt, logic [15:0] ns,
                          logic hc, logic [7:0] rb, logic tr);
    policy_item_t it;
    it = '{c, t, nt, ns, hc, rb, tr};
    item_q.push_back(it);
  endtask

  function automatic logic [63:0] pick_tag();
    if ($urandom_range(9) == 0) return {$urandom, $urandom};
    return tag_pool[$urandom_range(NPOOL - 1)];
  endfunction

  task automatic add_random();
    int k;
    cmd_e c;
    logic [7:0] rb;
    k = $urandom_range(99);
    c = (k < 40) ? CMD_SEEN : (k < 60) ? CMD_DELETED : (k < 95) ? CMD_QUERY : CMD_NONE;
    rb = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(2));
    add_item(c, pick_tag(), pick_tag(),
             ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(600)),
             1'($urandom), rb, $urandom_range(9) == 0);
  endtask

  task automatic drain();
    while (item_q.size() != 0 || s_axis_tvalid || result_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [23:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    pred_limit = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int cnt);
    for (int i = 0; i < cnt; i++) add_random();
    drain();
  endtask

  initial begin
    for (int i = 0; i < NREC; i++) rec_valid[i] = 1'b0;
    for (int i = 0; i < NPOOL; i++) tag_pool[i] = {$urandom, $urandom};
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, reset value of the limit
    add_item(CMD_SEEN, '0, '1, '1, 1'b1, 8'd0, 1'b0);
    add_item(CMD_SEEN, '1, '0, '0, 1'b0, 8'd255, 1'b0);
    add_item(CMD_SEEN, 64'h5, '0, '0, 1'b0, 8'd0, 1'b0);       // nothing to record
    add_item(CMD_SEEN, 64'h6, '1, '1, 1'b1, 8'd255, 1'b1);     // retranslation, ignored
    add_item(CMD_QUERY, '0, '1, 16'd100, 1'b0, 8'd0, 1'b0);    // arms return lookahead
    add_item(CMD_QUERY, '0, '1, 16'd100, 1'b0, 8'd0, 1'b0);
    add_item(CMD_QUERY, '0, '1, 16'd100, 1'b0, 8'd0, 1'b0);
    add_item(CMD_QUERY, 64'h77, '0, '1, 1'b1, 8'd255, 1'b1);   // next is a call head
    add_item(CMD_QUERY, 64'h77, 64'h78, '0, 1'b0, 8'd0, 1'b0);
    add_item(CMD_QUERY, '0, 64'h78, '1, 1'b0, 8'd0, 1'b0);     // over the size limit
    add_item(CMD_DELETED, 64'h99, '0, '0, 1'b0, 8'd0, 1'b0);   // unknown tag
    add_item(CMD_DELETED, '0, '1, '1, 1'b1, 8'd255, 1'b1);     // count 1 frees
    add_item(CMD_DELETED, '1, '0, '0, 1'b0, 8'd0, 1'b0);
    add_item(CMD_NONE, '1, '1, '1, 1'b1, 8'd255, 1'b1);
    add_item(CMD_NONE, '0, '0, '0, 1'b0, 8'd0, 1'b0);
    add_item(CMD_SEEN, 64'hA, '0, '0, 1'b1, 8'd255, 1'b0);
    add_item(CMD_SEEN, 64'hA, '0, '0, 1'b1, 8'd3, 1'b0);
    add_item(CMD_QUERY, 64'hA, 64'hA, 16'd1, 1'b0, 8'd0, 1'b0);
    drain();

    write_limit(SizeMax);
    // saturate one record's count, then its trace size
    for (int i = 0; i < 260; i++) add_item(CMD_SEEN, 64'hC0DE, '0, '0, 1'b1, 8'd255, 1'b0);
    for (int i = 0; i < 260; i++)
      add_item(CMD_QUERY, 64'hC0DE, {$urandom, $urandom}, 16'hFFFF, 1'b0, 8'd0, 1'b0);
    add_item(CMD_DELETED, 64'hC0DE, '0, '0, 1'b0, 8'd0, 1'b0);
    send_idle = 24; recv_idle = 47;
    random_phase(300);

    write_limit(24'($urandom_range(8000, 500)));
    send_idle = 47; recv_idle = 24;
    random_phase(380);

    write_limit('0);
    send_idle = 0; recv_idle = 0;
    random_phase(150);
    write_limit(24'($urandom));
    random_phase(200);

    $display("Sent %0d beats (seen, deleted, query, unused) over five limit settings.", n_sent);
    $display("Checked %0d results: %0d trace ends, %0d dropped inserts.", n_recv, n_end, n_full);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
